// File: hdl/cocp_pkg.sv
// shared types and constants for the capsule closest-points pipeline
`default_nettype none

package cocp_pkg;

  localparam int QBITS = 16;
  localparam int DIST_W = 34;
  localparam int PACK_W = 48;
  localparam int RAD_W = 16;
  localparam int THR_W = 16;

  localparam logic [QBITS:0] ONE_Q16 = {1'b1, {QBITS{1'b0}}};
  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef enum logic [1:0] {
    QC_ZERO,
    QC_ONE,
    QC_DIV
  } qcls_e;

  typedef struct packed {
    logic              overlap;
    logic [DIST_W-1:0] distance_sq;
    logic [QBITS:0]    s_param;
    logic [QBITS:0]    t_param;
    logic [PACK_W-1:0] a_closest;
    logic [PACK_W-1:0] b_closest;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/cocp_div.sv
// pipelined restoring divider giving a clamped Q1.16 ratio, one quotient bit per stage
`default_nettype none

module cocp_div import cocp_pkg::*; #(
  parameter int W = 71
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] num_i,
  input  logic signed [W-1:0] den_i,
  output logic [QBITS:0]      q_o
);

  qcls_e            cls_d;
  qcls_e            cls_q [QBITS+1];
  logic [W-1:0]     rem_q [QBITS+1];
  logic [W-1:0]     den_q [QBITS+1];
  logic [QBITS-1:0] quo_q [QBITS+1];
  logic [W-1:0]     sh    [1:QBITS];
  logic             ge    [1:QBITS];

  always_comb begin
    if (num_i <= 0) begin
      cls_d = QC_ZERO;
    end else if (den_i < $signed(W'(1)) || num_i >= den_i) begin
      cls_d = QC_ONE;
    end else begin
      cls_d = QC_DIV;
    end
  end

  always_comb begin
    for (int k = 1; k <= QBITS; k++) begin
      sh[k] = rem_q[k-1] << 1;
      ge[k] = sh[k] >= den_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls_q[0] <= cls_d;
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      for (int k = 1; k <= QBITS; k++) begin
        cls_q[k] <= cls_q[k-1];
        rem_q[k] <= ge[k] ? sh[k] - den_q[k-1] : sh[k];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= {quo_q[k-1][QBITS-2:0], ge[k]};
      end
    end
  end

  always_comb begin
    case (cls_q[QBITS])
      QC_ZERO: q_o = '0;
      QC_ONE:  q_o = ONE_Q16;
      default: q_o = {1'b0, quo_q[QBITS]};
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/capsule_overlap_closest_points_core.sv
// capsule overlap test: closest points of two 3d segments, squared distance and overlap flag
//
// Fully pipelined: one segment pair enters per clock while the skid entry is
// empty. The pipeline holds the difference, dot-product, 2x2 product,
// determinant and clamp stages, the two divider pipelines (one quotient bit
// per stage) and the scaling, closest-point and squaring stages. All stages
// advance together; a two-entry output buffer (output register plus skid) lets
// one more transaction enter while a result waits, and input ready comes straight from a flop.
`default_nettype none

module capsule_overlap_closest_points_core import cocp_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [THR_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PACK_W-1:0] a_start_i,
  input  logic [PACK_W-1:0] a_end_i,
  input  logic [PACK_W-1:0] b_start_i,
  input  logic [PACK_W-1:0] b_end_i,
  input  logic [RAD_W-1:0]  a_radius_i,
  input  logic [RAD_W-1:0]  b_radius_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              overlap_o,
  output logic [DIST_W-1:0] distance_sq_o,
  output logic [QBITS:0]    s_param_o,
  output logic [QBITS:0]    t_param_o,
  output logic [PACK_W-1:0] a_closest_o,
  output logic [PACK_W-1:0] b_closest_o
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int DOTW = 2 * DW + 1;
  localparam int NW = DOTW + 1;
  localparam int PRW = 2 * DOTW;
  localparam int PW = 2 * DOTW + 1;
  localparam int SW = QBITS + 2;
  localparam int USW = DW + SW;
  localparam int SQW = 2 * DW;
  localparam int DISTW = SQW + 2;
  localparam int CMPW = (DISTW > DIST_W) ? DISTW : DIST_W;
  localparam int LW = (3 * CW > PACK_W) ? 3 * CW : PACK_W;
  localparam int RSW = RAD_W + 1;
  localparam int NDIV = QBITS + 1;
  localparam int LAST = NDIV + 9;

  typedef struct packed {
    logic [2:0][CW-1:0] a0;
    logic [2:0][CW-1:0] b0;
    logic [2:0][DW-1:0] u;
    logic [2:0][DW-1:0] v;
    logic [DIST_W-1:0]  rsq;
  } side_t;

  // control
  logic [THR_W-1:0] thr_q;
  logic [LAST:1]    vld_q;
  logic             adv;
  logic             push;
  logic             pop;
  logic             out_vld_q;
  logic             skid_vld_q;
  res_t             out_q;
  res_t             skid_q;
  res_t             res_d;

  assign cfg_ready_o = 1'b1;
  assign adv = !skid_vld_q;
  assign in_ready_o = adv;
  assign push = vld_q[LAST] && adv;
  assign pop = out_vld_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAST-1:1], in_valid_i};
    end
  end

  // stage 1: lane split and differences
  logic [LW-1:0]       as_x, ae_x, bs_x, be_x;
  logic [2:0][CW-1:0]  a0_1q, b0_1q;
  logic [2:0][DW-1:0]  u_1d, v_1d, w_1d, u_1q, v_1q, w_1q;
  logic [RSW-1:0]      rsum_1q;

  assign as_x = LW'(a_start_i);
  assign ae_x = LW'(a_end_i);
  assign bs_x = LW'(b_start_i);
  assign be_x = LW'(b_end_i);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u_1d[k] = DW'($signed(ae_x[k*CW +: CW])) - DW'($signed(as_x[k*CW +: CW]));
      v_1d[k] = DW'($signed(be_x[k*CW +: CW])) - DW'($signed(bs_x[k*CW +: CW]));
      w_1d[k] = DW'($signed(as_x[k*CW +: CW])) - DW'($signed(bs_x[k*CW +: CW]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        a0_1q[k] <= as_x[k*CW +: CW];
        b0_1q[k] <= bs_x[k*CW +: CW];
      end
      u_1q    <= u_1d;
      v_1q    <= v_1d;
      w_1q    <= w_1d;
      rsum_1q <= RSW'(a_radius_i) + RSW'(b_radius_i);
    end
  end

  // stage 2: dot products
  function automatic logic signed [DOTW-1:0] dot3(
    input logic [2:0][DW-1:0] x,
    input logic [2:0][DW-1:0] y
  );
    logic signed [2*DW-1:0] p0, p1, p2;
    p0 = $signed(x[0]) * $signed(y[0]);
    p1 = $signed(x[1]) * $signed(y[1]);
    p2 = $signed(x[2]) * $signed(y[2]);
    return DOTW'(p0) + DOTW'(p1) + DOTW'(p2);
  endfunction

  logic signed [DOTW-1:0] a_2q, b_2q, c_2q, d_2q, e_2q;
  side_t                  sd_2q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_2q <= dot3(u_1q, u_1q);
      b_2q <= dot3(u_1q, v_1q);
      c_2q <= dot3(v_1q, v_1q);
      d_2q <= dot3(u_1q, w_1q);
      e_2q <= dot3(v_1q, w_1q);
      sd_2q.a0  <= a0_1q;
      sd_2q.b0  <= b0_1q;
      sd_2q.u   <= u_1q;
      sd_2q.v   <= v_1q;
      sd_2q.rsq <= DIST_W'(rsum_1q) * DIST_W'(rsum_1q);
    end
  end

  // stage 3: products of dot products
  logic signed [PRW-1:0]  ac_3q, bb_3q, be_3q, cd_3q, ae_3q, bd_3q;
  logic signed [DOTW-1:0] a_3q, b_3q, c_3q, d_3q, e_3q;
  side_t                  sd_3q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ac_3q <= a_2q * c_2q;
      bb_3q <= b_2q * b_2q;
      be_3q <= b_2q * e_2q;
      cd_3q <= c_2q * d_2q;
      ae_3q <= a_2q * e_2q;
      bd_3q <= b_2q * d_2q;
      a_3q  <= a_2q;
      b_3q  <= b_2q;
      c_3q  <= c_2q;
      d_3q  <= d_2q;
      e_3q  <= e_2q;
      sd_3q <= sd_2q;
    end
  end

  // stage 4: determinant and numerators
  logic signed [PW-1:0]   det_4q, sn_4q, tn_4q;
  logic signed [DOTW-1:0] a_4q, b_4q, c_4q, d_4q, e_4q;
  side_t                  sd_4q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      det_4q <= PW'(ac_3q) - PW'(bb_3q);
      sn_4q  <= PW'(be_3q) - PW'(cd_3q);
      tn_4q  <= PW'(ae_3q) - PW'(bd_3q);
      a_4q   <= a_3q;
      b_4q   <= b_3q;
      c_4q   <= c_3q;
      d_4q   <= d_3q;
      e_4q   <= e_3q;
      sd_4q  <= sd_3q;
    end
  end

  // stage 5: parallel case and s clamp
  logic signed [PW-1:0]   sn_5d, sd_5d, tn_5d, td_5d, thr_x, e_x, c_x, eb_x;
  logic signed [PW-1:0]   sn_5q, sd_5q, tn_5q, td_5q;
  logic signed [NW-1:0]   nd_5q, nb_5q;
  logic signed [DOTW-1:0] a_5q;
  side_t                  sd_5q2;

  always_comb begin
    thr_x = $signed({{(PW-THR_W){1'b0}}, thr_q});
    e_x   = PW'(e_4q);
    c_x   = PW'(c_4q);
    eb_x  = PW'(e_4q) + PW'(b_4q);
    if (det_4q <= thr_x) begin
      sn_5d = '0;
      sd_5d = PW'(1);
      tn_5d = e_x;
      td_5d = c_x;
    end else begin
      sn_5d = sn_4q;
      sd_5d = det_4q;
      tn_5d = tn_4q;
      td_5d = det_4q;
      if (sn_4q < 0) begin
        sn_5d = '0;
        tn_5d = e_x;
        td_5d = c_x;
      end else if (sn_4q > det_4q) begin
        sn_5d = det_4q;
        tn_5d = eb_x;
        td_5d = c_x;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sn_5q  <= sn_5d;
      sd_5q  <= sd_5d;
      tn_5q  <= tn_5d;
      td_5q  <= td_5d;
      nd_5q  <= -NW'(d_4q);
      nb_5q  <= NW'(b_4q) - NW'(d_4q);
      a_5q   <= a_4q;
      sd_5q2 <= sd_4q;
    end
  end

  // stage 6: t clamp and s recompute
  logic signed [PW-1:0] sn_6d, sd_6d, tn_6d, sn_6q, sd_6q, tn_6q, td_6q;
  logic signed [NW-1:0] n_6;
  side_t                sd_6q2;

  always_comb begin
    sn_6d = sn_5q;
    sd_6d = sd_5q;
    tn_6d = tn_5q;
    n_6   = (tn_5q < 0) ? nd_5q : nb_5q;
    if (tn_5q < 0 || tn_5q > td_5q) begin
      tn_6d = (tn_5q < 0) ? '0 : td_5q;
      if (n_6 < 0) begin
        sn_6d = '0;
      end else if (n_6 > NW'(a_5q)) begin
        sn_6d = sd_5q;
      end else begin
        sn_6d = PW'(n_6);
        sd_6d = PW'(a_5q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sn_6q  <= sn_6d;
      sd_6q  <= sd_6d;
      tn_6q  <= tn_6d;
      td_6q  <= td_5q;
      sd_6q2 <= sd_5q2;
    end
  end

  // divider stages
  logic [QBITS:0] s_div, t_div;
  side_t          side_q [NDIV];

  cocp_div #(.W(PW)) u_sdiv (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (sn_6q),
    .den_i (sd_6q),
    .q_o   (s_div)
  );

  cocp_div #(.W(PW)) u_tdiv (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (tn_6q),
    .den_i (td_6q),
    .q_o   (t_div)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= sd_6q2;
      for (int k = 1; k < NDIV; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // scaled direction vectors
  logic signed [USW-1:0] us_q [3];
  logic signed [USW-1:0] vt_q [3];
  logic [QBITS:0]        s_uq, t_uq;
  side_t                 sd_uq;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        us_q[k] <= $signed(side_q[NDIV-1].u[k]) * $signed({1'b0, s_div});
        vt_q[k] <= $signed(side_q[NDIV-1].v[k]) * $signed({1'b0, t_div});
      end
      s_uq  <= s_div;
      t_uq  <= t_div;
      sd_uq <= side_q[NDIV-1];
    end
  end

  // closest points
  logic signed [USW-1:0] pa_x [3];
  logic signed [USW-1:0] pb_x [3];
  logic [2:0][CW-1:0]    pa_q, pb_q;
  logic [QBITS:0]        s_pq, t_pq;
  logic [DIST_W-1:0]     rsq_pq;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pa_x[k] = USW'($signed(sd_uq.a0[k])) + (us_q[k] >>> QBITS);
      pb_x[k] = USW'($signed(sd_uq.b0[k])) + (vt_q[k] >>> QBITS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        pa_q[k] <= pa_x[k][CW-1:0];
        pb_q[k] <= pb_x[k][CW-1:0];
      end
      s_pq   <= s_uq;
      t_pq   <= t_uq;
      rsq_pq <= sd_uq.rsq;
    end
  end

  // squared components
  logic signed [DW-1:0]  df [3];
  logic signed [SQW-1:0] sqp [3];
  logic [SQW-1:0]        sq_q [3];
  logic [2:0][CW-1:0]    pa_sq, pb_sq;
  logic [QBITS:0]        s_sq, t_sq;
  logic [DIST_W-1:0]     rsq_sq;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      df[k]  = DW'($signed(pa_q[k])) - DW'($signed(pb_q[k]));
      sqp[k] = df[k] * df[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= sqp[k];
      end
      pa_sq  <= pa_q;
      pb_sq  <= pb_q;
      s_sq   <= s_pq;
      t_sq   <= t_pq;
      rsq_sq <= rsq_pq;
    end
  end

  // distance, overlap and packing
  logic [CMPW-1:0] dist_c;
  logic [LW-1:0]   pka, pkb;

  always_comb begin
    dist_c = CMPW'(DISTW'(sq_q[0]) + DISTW'(sq_q[1]) + DISTW'(sq_q[2]));
    pka = '0;
    pkb = '0;
    for (int k = 0; k < 3; k++) begin
      pka[k*CW +: CW] = pa_sq[k];
      pkb[k*CW +: CW] = pb_sq[k];
    end
    res_d.overlap     = dist_c <= CMPW'(rsq_sq);
    res_d.distance_sq = (dist_c > CMPW'(DIST_MAX)) ? DIST_MAX : dist_c[DIST_W-1:0];
    res_d.s_param     = s_sq;
    res_d.t_param     = t_sq;
    res_d.a_closest   = pka[PACK_W-1:0];
    res_d.b_closest   = pkb[PACK_W-1:0];
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (pop || !out_vld_q) begin
      out_vld_q  <= skid_vld_q || push;
      skid_vld_q <= 1'b0;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_vld_q) begin
      out_q <= skid_vld_q ? skid_q : res_d;
    end else if (push) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign overlap_o     = out_q.overlap;
  assign distance_sq_o = out_q.distance_sq;
  assign s_param_o     = out_q.s_param;
  assign t_param_o     = out_q.t_param;
  assign a_closest_o   = out_q.a_closest;
  assign b_closest_o   = out_q.b_closest;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry held without output entry");

  a_s_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> s_param_o <= ONE_Q16)
    else $error("s parameter above one");

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> t_param_o <= ONE_Q16)
    else $error("t parameter above one");

  a_miss_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !overlap_o |-> distance_sq_o != '0)
    else $error("no overlap reported at zero distance");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i && vld_q[LAST] |=> skid_vld_q)
    else $error("finished transaction lost while output stalled");

endmodule

`default_nettype wire
